[sv/svu_pkg.sv]
// Shared types and constants for the softmax vector unit.
// Depends on nothing; svu_div, the top level, the checker and the testbench import it.
`timescale 1ns / 1ps

package svu_pkg;

   localparam int SVU_MAX_LEN      = 64;
   localparam int SVU_SCORE_W      = 16;
   localparam int SVU_EXP_W        = 17;
   localparam int SVU_PROB_W       = 16;
   localparam int SVU_SUM_W        = 23;
   localparam int SVU_Q30_W        = 31;
   localparam int SVU_MUL_W        = 31;
   localparam int SVU_PROD_W       = 2 * SVU_MUL_W;
   localparam int SVU_DIVIDEND_W   = 41;
   localparam int SVU_DIVISOR_W    = 23;
   localparam int SVU_RECIP_W      = 25;
   localparam int SVU_T_W          = 13;
   localparam int SVU_TERM_W       = 4;
   localparam int SVU_EXP_CUTOFF   = 4096;
   localparam int SVU_HORNER_TERMS = 10;
   localparam int SVU_SQUARINGS    = 5;

   // Q30 representation of 1.0
   localparam logic [SVU_Q30_W-1:0] SVU_Q30_ONE = SVU_Q30_W'(1 << 30);

   typedef struct packed {
      logic                      start;
      logic [SVU_DIVIDEND_W-1:0] dividend;
      logic [SVU_DIVISOR_W-1:0]  divisor;
   } div_req_type;

endpackage

[sv/svu_ram.sv]
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module svu_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/svu_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Depends on svu_pkg for widths and the request struct.
`timescale 1ns / 1ps

module svu_div
   import svu_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  div_req_type               req,
   output logic                      done,
   output logic [SVU_DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(SVU_DIVIDEND_W + 1);

   logic                      busy_ff;
   logic                      done_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [SVU_DIVISOR_W-1:0]  rem_ff;
   logic [SVU_DIVISOR_W-1:0]  dvs_ff;
   logic [SVU_DIVIDEND_W-1:0] quo_ff;
   logic [SVU_DIVISOR_W:0]    trial;
   logic                      fits;

   assign trial = {rem_ff, quo_ff[SVU_DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            dvs_ff  <= req.divisor;
            quo_ff  <= req.dividend;
         end else if (busy_ff) begin
            rem_ff <= fits ? SVU_DIVISOR_W'(trial - {1'b0, dvs_ff})
                           : trial[SVU_DIVISOR_W-1:0];
            quo_ff <= {quo_ff[SVU_DIVIDEND_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SVU_DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/softmax_vector_unit.sv]
// Softmax vector unit, top level: load sequencer, shared multiplier and pass control.
// Depends on svu_pkg, svu_ram and svu_div.
`timescale 1ns / 1ps

// The unit takes a vector of signed Q8.8 scores, one transaction per element, and
// keeps the running maximum. req_ready stays high while loading. The transaction
// marked is_last starts two passes over the stored elements, during which req_ready
// is low. The first pass computes exp(score - max) in unsigned Q1.16 with a ten-term
// Horner series followed by five squarings. Every Horner term is a product in the
// shared multiplier, a division by the term number done as a product with a
// tabulated reciprocal in the same multiplier, and a subtraction. Each squaring is a
// product in the shared multiplier followed by rounding. When the argument lies below
// -16 the result flushes to zero and the series is skipped. The reciprocal of the
// sum is then formed in a serial divider. The second pass emits the probabilities
// one by one and forms the next only after rsp_ready has taken the last. Elements
// beyond MAX_LEN are dropped and every result of that vector then carries
// rsp_overflowed. After the last result the unit is ready for a new vector.

module softmax_vector_unit
   import svu_pkg::*;
#(
   parameter int MAX_LEN = SVU_MAX_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_score,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_probability,
   output logic                  rsp_final_result,
   output logic                  rsp_overflowed
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW = $clog2(MAX_LEN + 1);

   typedef enum logic [3:0] {
      S_LOAD, S_RD, S_T, S_HMUL, S_HREC, S_HSUB, S_SQMUL, S_SQ,
      S_E, S_RDIV, S_RWAIT, S_ORD, S_OMUL, S_OFMT, S_OUT
   } state_type;

   state_type                   state_ff;
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               idx_ff;
   logic signed [SVU_SCORE_W-1:0] max_ff;
   logic [SVU_SUM_W-1:0]        sum_ff;
   logic                        drop_ff;
   logic [SVU_T_W-1:0]          t_ff;
   logic [SVU_Q30_W-1:0]        p_ff;
   logic [SVU_TERM_W-1:0]       n_ff;
   logic [2:0]                  k_ff;
   logic [SVU_RECIP_W-1:0]      recip_ff;
   logic [SVU_PROD_W-1:0]       prod_ff;
   logic [SVU_PROB_W-1:0]       prob_ff;
   logic                        final_ff;

   // Memory port signals
   logic                        ram_we;
   logic [AW-1:0]               ram_waddr;
   logic [SVU_EXP_W-1:0]        ram_wdata;
   logic [SVU_EXP_W-1:0]        ram_rdata;

   // Shared multiplier operands
   logic [SVU_MUL_W-1:0]        mul_a;
   logic [SVU_MUL_W-1:0]        mul_b;

   // Reciprocal of the Horner term number and the shift that goes with it
   logic [SVU_MUL_W-1:0]        recip_n;
   logic [5:0]                  recip_sh;
   logic [SVU_Q30_W-1:0]        horner_q;

   div_req_type                 div_req;
   logic                        div_done;
   logic [SVU_DIVIDEND_W-1:0]   div_q;

   // Datapath helpers
   logic signed [SVU_SCORE_W:0] diff;
   logic [SVU_PROD_W:0]         sq_round;
   logic [SVU_Q30_W:0]          e_round;
   logic [SVU_EXP_W-1:0]        e_val;
   logic [42:0]                 pr_round;
   logic [18:0]                 pr_val;
   logic                        accept;
   logic                        store_ok;

   assign accept   = req_valid && req_ready;
   assign store_ok = count_ff < CW'(MAX_LEN);

   assign diff     = {max_ff[SVU_SCORE_W-1], max_ff}
                   - {ram_rdata[SVU_SCORE_W-1], ram_rdata[SVU_SCORE_W-1:0]};
   assign sq_round = {1'b0, prod_ff} + (SVU_PROD_W + 1)'(1 << 29);
   assign e_round  = {1'b0, p_ff} + (SVU_Q30_W + 1)'(8192);
   assign e_val    = e_round[30:14];
   assign pr_round = prod_ff[42:0] + 43'(1 << 23);
   assign pr_val   = pr_round[42:24];

   // Division by the term number n is a product with ceil(2^s / n) followed by a
   // shift by s = 30 + ceil(log2 n). The quotient is exact for every dividend below
   // 2^30, and the Horner dividend never exceeds 2^29.
   always_comb begin
      case (n_ff)
         4'd2: begin
            recip_n  = 31'd1073741824;
            recip_sh = 6'd31;
         end
         4'd3: begin
            recip_n  = 31'd1431655766;
            recip_sh = 6'd32;
         end
         4'd4: begin
            recip_n  = 31'd1073741824;
            recip_sh = 6'd32;
         end
         4'd5: begin
            recip_n  = 31'd1717986919;
            recip_sh = 6'd33;
         end
         4'd6: begin
            recip_n  = 31'd1431655766;
            recip_sh = 6'd33;
         end
         4'd7: begin
            recip_n  = 31'd1227133514;
            recip_sh = 6'd33;
         end
         4'd8: begin
            recip_n  = 31'd1073741824;
            recip_sh = 6'd33;
         end
         4'd9: begin
            recip_n  = 31'd1908874354;
            recip_sh = 6'd34;
         end
         4'd10: begin
            recip_n  = 31'd1717986919;
            recip_sh = 6'd34;
         end
         default: begin
            recip_n  = 31'd1073741824;
            recip_sh = 6'd30;
         end
      endcase
   end

   assign horner_q = SVU_Q30_W'(prod_ff >> recip_sh);

   // The store holds the raw score during loading and is overwritten with the
   // exponential of the same element in the first pass.
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = count_ff[AW-1:0];
      ram_wdata = {req_score[15], req_score};
      if (state_ff == S_LOAD) begin
         ram_we = accept && store_ok;
      end else if (state_ff == S_E) begin
         ram_we    = 1'b1;
         ram_waddr = idx_ff[AW-1:0];
         ram_wdata = e_val;
      end else if (state_ff == S_T) begin
         ram_we    = diff > (SVU_SCORE_W + 1)'(SVU_EXP_CUTOFF);
         ram_waddr = idx_ff[AW-1:0];
         ram_wdata = '0;
      end
   end

   always_comb begin
      mul_a = p_ff;
      mul_b = p_ff;
      case (state_ff)
         S_HMUL: mul_a = SVU_MUL_W'({t_ff, 17'b0});
         S_HREC: begin
            mul_a = prod_ff[60:30];
            mul_b = recip_n;
         end
         S_OMUL: begin
            mul_a = SVU_MUL_W'(ram_rdata);
            mul_b = SVU_MUL_W'(recip_ff);
         end
         default: ;
      endcase
   end

   // The serial divider only forms the reciprocal of the sum.
   always_comb begin
      div_req.start    = (state_ff == S_RDIV);
      div_req.dividend = (SVU_DIVIDEND_W'(1) << 40)
                       + SVU_DIVIDEND_W'(sum_ff >> 1);
      div_req.divisor  = sum_ff;
   end

   svu_ram #(
      .WIDTH(SVU_EXP_W),
      .DEPTH(1 << AW)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   svu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         idx_ff   <= '0;
         max_ff   <= SVU_SCORE_W'(1 << (SVU_SCORE_W - 1));
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (store_ok) begin
                     count_ff <= count_ff + 1'b1;
                     if (req_score > max_ff) begin
                        max_ff <= req_score;
                     end
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_is_last) begin
                     idx_ff   <= '0;
                     sum_ff   <= '0;
                     state_ff <= S_RD;
                  end
               end
            end
            S_RD: state_ff <= S_T;
            S_T: begin
               t_ff <= diff[SVU_T_W-1:0];
               p_ff <= SVU_Q30_ONE;
               n_ff <= SVU_TERM_W'(SVU_HORNER_TERMS);
               k_ff <= '0;
               if (diff > (SVU_SCORE_W + 1)'(SVU_EXP_CUTOFF)) begin
                  // Argument below -16: the exponential flushes to zero.
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= (idx_ff + 1'b1 == count_ff) ? S_RDIV : S_RD;
               end else begin
                  state_ff <= S_HMUL;
               end
            end
            S_HMUL: state_ff <= S_HREC;
            S_HREC: state_ff <= S_HSUB;
            S_HSUB: begin
               p_ff <= SVU_Q30_ONE - horner_q;
               n_ff <= n_ff - 1'b1;
               state_ff <= (n_ff == SVU_TERM_W'(1)) ? S_SQMUL : S_HMUL;
            end
            S_SQMUL: state_ff <= S_SQ;
            S_SQ: begin
               p_ff <= sq_round[60:30];
               k_ff <= k_ff + 1'b1;
               state_ff <= (k_ff == 3'(SVU_SQUARINGS - 1)) ? S_E : S_SQMUL;
            end
            S_E: begin
               sum_ff <= sum_ff + SVU_SUM_W'(e_val);
               idx_ff <= idx_ff + 1'b1;
               state_ff <= (idx_ff + 1'b1 == count_ff) ? S_RDIV : S_RD;
            end
            S_RDIV: state_ff <= S_RWAIT;
            S_RWAIT: begin
               if (div_done) begin
                  recip_ff <= (sum_ff == '0) ? '0 : div_q[SVU_RECIP_W-1:0];
                  idx_ff   <= '0;
                  state_ff <= S_ORD;
               end
            end
            S_ORD:  state_ff <= S_OMUL;
            S_OMUL: state_ff <= S_OFMT;
            S_OFMT: begin
               prob_ff  <= (pr_val[18:16] != 3'b000) ? '1 : pr_val[15:0];
               final_ff <= (idx_ff + 1'b1 == count_ff);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  idx_ff <= idx_ff + 1'b1;
                  if (final_ff) begin
                     count_ff <= '0;
                     max_ff   <= SVU_SCORE_W'(1 << (SVU_SCORE_W - 1));
                     sum_ff   <= '0;
                     drop_ff  <= 1'b0;
                     state_ff <= S_LOAD;
                  end else begin
                     state_ff <= S_ORD;
                  end
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

   assign req_ready        = (state_ff == S_LOAD);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_probability  = prob_ff;
   assign rsp_final_result = final_ff;
   assign rsp_overflowed   = drop_ff;

   // A result is never offered while loading is open.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("result offered while accepting input");

   // The element count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(MAX_LEN))
      else $error("element count beyond capacity");

   // Once the final result of a vector is taken, the unit is ready again.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_result) |=> req_ready)
      else $error("not ready after final result");

   // A result index always refers to a stored element.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> idx_ff < count_ff)
      else $error("result index beyond stored elements");

endmodule

[sim/softmax_vector_unit_checker.sv]
// Checker for the softmax vector unit: watches both channels, predicts every probability
// and compares it with what the unit emits. Depends on svu_pkg.
`timescale 1ns / 1ps

module softmax_vector_unit_checker
   import svu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_score,
   input  logic               req_is_last,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [15:0]        rsp_probability,
   input  logic               rsp_final_result,
   input  logic               rsp_overflowed,
   output int                 error_count,
   output int                 pending_count
);

   typedef struct packed {
      logic [15:0] probability;
      logic        final_result;
      logic        overflowed;
   } prob_type;

   logic signed [15:0] vec_scores[$];
   logic signed [15:0] vec_max;
   logic               vec_dropped;
   prob_type           prob_queue[$];

   function automatic logic [16:0] exp_q16(logic [15:0] t);
      logic [63:0] u;
      logic [63:0] p;
      if (t > 16'(SVU_EXP_CUTOFF)) return 17'd0;
      u = 64'(t) << 17;
      p = 64'd1 << 30;
      for (int n = 10; n >= 1; n--)
         p = (64'd1 << 30) - (((u * p) >> 30) / 64'(n));
      for (int k = 0; k < 5; k++)
         p = (p * p + (64'd1 << 29)) >> 30;
      return 17'((p + 64'd8192) >> 14);
   endfunction

   task automatic predict_vector();
      logic [16:0] exps[$];
      logic [22:0] total;
      logic [63:0] recip;
      logic [63:0] pr;
      prob_type    item;
      total = '0;
      foreach (vec_scores[i]) begin
         exps.push_back(exp_q16(16'(vec_max - vec_scores[i])));
         total = total + 23'(exps[i]);
      end
      recip = (total != 0) ? (((64'd1 << 40) + 64'(total >> 1)) / 64'(total)) : 64'd0;
      foreach (exps[i]) begin
         pr = (64'(exps[i]) * recip + (64'd1 << 23)) >> 24;
         item.probability  = (pr > 64'd65535) ? 16'hFFFF : pr[15:0];
         item.final_result = (i == exps.size() - 1);
         item.overflowed   = vec_dropped;
         prob_queue.push_back(item);
      end
      vec_scores.delete();
      vec_max     = -16'sd32768;
      vec_dropped = 1'b0;
   endtask

   assign pending_count = prob_queue.size();

   always @(posedge clock) begin
      prob_type got;
      prob_type want;
      if (reset) begin
         vec_scores.delete();
         prob_queue.delete();
         vec_max     = -16'sd32768;
         vec_dropped = 1'b0;
         error_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            if (vec_scores.size() < SVU_MAX_LEN) begin
               vec_scores.push_back(req_score);
               if (req_score > vec_max) vec_max = req_score;
            end else begin
               vec_dropped = 1'b1;
            end
            if (req_is_last) predict_vector();
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_probability, rsp_final_result, rsp_overflowed};
            if (prob_queue.size() == 0) begin
               $display("%0t: unexpected result transaction, actual %p", $time, got);
               error_count <= error_count + 1;
            end else begin
               want = prob_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

[sim/softmax_vector_unit_tb.sv]
// Testbench top for the softmax vector unit: clock, reset, stimulus and the verdict.
// Depends on svu_pkg, the unit itself and softmax_vector_unit_checker.
`timescale 1ns / 1ps

module softmax_vector_unit_tb;
   import svu_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_score = '0;
   logic               req_is_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [15:0]        rsp_probability;
   logic               rsp_final_result;
   logic               rsp_overflowed;
   int                 error_count;
   int                 pending_count;
   bit                 long_hold = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   softmax_vector_unit i_dut (.*);

   softmax_vector_unit_checker i_checker (.*);

   // Sends one element and waits until the transaction has been accepted.
   task automatic send_score(input logic signed [15:0] score, input logic last);
      req_valid   <= 1'b1;
      req_score   <= score;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Now and then drops valid for a random gap; the sender works in bursts, so most calls add nothing.
   task automatic maybe_gap();
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // A vector whose scores lie within spread above a random base; a small spread keeps most
   // exponentials non-zero, so that the long Horner pass is exercised.
   task automatic send_vector(input int len, input int spread);
      int base;
      base = $urandom_range(0, 65535) - 32768;
      for (int i = 0; i < len; i++) begin
         send_score(16'(base + $urandom_range(0, spread)), i == len - 1);
         maybe_gap();
      end
   endtask

   // The receiver stalls on its own pattern; during a long hold it refuses everything.
   always @(posedge clock) begin
      if (reset || long_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) < 3);
   end

   initial begin
      int sent;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A single element gives a probability of one, which saturates.
      send_score(16'sh7FFF, 1'b1);
      send_score(-16'sd32768, 1'b1);
      // The full range of scores: the smaller one lies far below -16 and flushes to zero.
      send_score(-16'sd32768, 1'b0);
      send_score(16'sh7FFF, 1'b1);
      // Equal elements, and a difference exactly at the cut-off and one step past it.
      send_score(16'sd256, 1'b0);
      send_score(16'sd256, 1'b0);
      send_score(16'sd256, 1'b1);
      send_score(16'sd0, 1'b0);
      send_score(-16'sd4096, 1'b0);
      send_score(-16'sd4097, 1'b1);
      // Two widely spread elements.
      send_score(16'sh5555, 1'b0);
      send_score(-16'sh5556, 1'b1);
      send_score(16'sd1, 1'b0);
      send_score(16'sd0, 1'b1);

      // Capacity exceeded: mostly flushed elements so the passes stay short, then two
      // dropped elements, the last of which still closes the vector.
      for (int i = 0; i < SVU_MAX_LEN + 2; i++)
         send_score((i == 0) ? 16'sd4000 : 16'(-20000 - i), i == SVU_MAX_LEN + 1);
      sent = 80;

      // Long receiver hold while the sender keeps offering, so the unit stalls with its results pending.
      long_hold = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         for (int v = 0; v < 3; v++) send_vector(3, 1200);
      join
      sent += 9;

      // Random part: mostly well-formed vectors of modest length, a few long ones with
      // wide spread, and now and then a lone element.
      while (sent < 450) begin
         int len;
         case ($urandom_range(0, 9))
            0: len = 1;
            1: len = $urandom_range(SVU_MAX_LEN - 2, SVU_MAX_LEN + 3);
            default: len = $urandom_range(2, 7);
         endcase
         if (len > 20) send_vector(len, 65535);
         else send_vector(len, ($urandom_range(0, 1) != 0) ? 65535 : 2000);
         sent += len;
      end
      req_valid <= 1'b0;

      // Give the checker time to queue the last vector's results.
      @(posedge clock);
      wait (pending_count == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("PASS softmax_vector_unit");
      else $display("FAIL softmax_vector_unit");
      $finish;
   end

   // Upper bound on the whole run, several times the slowest correct one.
   initial begin
      #80_000_000;
      $display("FAIL softmax_vector_unit");
      $finish;
   end

endmodule
